// ----- design/lpr_pkg.sv -----
// Shared types and constants for the LRU page replacement block.
// No dependencies; imported by lpr_ctrl, lpr_dpath and the top level of the block.
`default_nettype none

package lpr_pkg;

    // Field widths fixed by the stream format
    localparam int PAGE_W      = 16;
    localparam int SLOT_W      = 3;
    localparam int CNT_W       = 32;
    localparam int AF_W        = 4;
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 56;

    localparam logic [AF_W-1:0]  AF_RESET = 4'd8;
    localparam logic [CNT_W-1:0] CNT_MAX  = '1;

    // Command codes carried in tuser
    localparam logic CMD_REF   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Controller -> datapath
    typedef struct packed {
        logic load;    // take the input item, start a search
        logic step;    // issue next frame read
        logic commit;  // apply update or clear, load output register
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic in_clear;   // input item is a clear command
        logic scan_last;  // issuing the last active frame
        logic out_free;   // output register can take a result
    } ctrl_sts_t;

endpackage

`default_nettype wire

// ----- design/lpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                                 aclk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/lpr_ctrl.sv -----
// Sequencer for the LRU page replacement block.
// Depends on lpr_pkg for the command and status structs.
`default_nettype none

module lpr_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire lpr_pkg::ctrl_sts_t sts,
    output lpr_pkg::ctrl_cmd_t     cmd
);
    import lpr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                // no item is taken while reset is held
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_clear ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last frame compare lands this cycle
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/lpr_dpath.sv -----
// Datapath: frame tables, scan compare, counters and output register.
// Depends on lpr_pkg and lpr_ram.
`default_nettype none

module lpr_dpath #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire lpr_pkg::ctrl_cmd_t               cmd,
    output lpr_pkg::ctrl_sts_t                    sts,
    input  wire logic [lpr_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire logic [lpr_pkg::IN_TUSER_W-1:0]   s_tuser,
    input  wire logic                             cfg_wr_en,
    input  wire logic [lpr_pkg::AF_W-1:0]         cfg_wr_data,
    input  wire logic                             m_tready,
    output logic                                  m_tvalid,
    output logic      [lpr_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import lpr_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

    logic [AF_W-1:0]        af_reg;
    logic [FRAMES-1:0]      valid_reg;
    logic [CNT_W-1:0]       ref_cnt_reg;
    logic [CNT_W-1:0]       fault_reg;
    logic                   out_vld_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   cmp_vld_reg;

    logic [IW-1:0]          idx_reg;
    logic [IW-1:0]          cmp_idx_reg;
    logic                   clear_reg;
    logic [PW-1:0]          page_reg;
    logic [CNT_W-1:0]       stamp_reg;
    logic                   hit_fnd_reg;
    logic [IW-1:0]          hit_slot_reg;
    logic                   emp_fnd_reg;
    logic [IW-1:0]          emp_slot_reg;
    logic [CNT_W-1:0]       best_stamp_reg;
    logic [IW-1:0]          best_slot_reg;
    logic [PW-1:0]          best_page_reg;

    logic [PW-1:0]          pg_rd;
    logic [CNT_W-1:0]       st_rd;
    logic [IW-1:0]          n_last;
    logic [IW-1:0]          slot_sel;
    logic                   miss;
    logic                   ev_valid;
    logic [CNT_W-1:0]       fault_next;
    logic [OUT_TDATA_W-1:0] out_data_next;
    logic                   cmp_v;
    logic                   pg_we;
    logic                   st_we;

    // Clamp active frame count to 1..FRAMES, as a last index
    always_comb begin
        if (af_reg == '0) begin
            n_last = '0;
        end else if ({{(CNT_W-AF_W){1'b0}}, af_reg} >= CNT_W'(FRAMES)) begin
            n_last = IW'(FRAMES - 1);
        end else begin
            n_last = IW'(af_reg - AF_W'(1));
        end
    end

    assign sts.in_clear  = (s_tuser[0] == CMD_CLEAR);
    assign sts.scan_last = (idx_reg == n_last);
    assign sts.out_free  = !out_vld_reg || m_tready;

    assign cmp_v    = valid_reg[cmp_idx_reg];
    assign miss     = !hit_fnd_reg;
    assign ev_valid = miss && !emp_fnd_reg;

    always_comb begin
        if (hit_fnd_reg) begin
            slot_sel = hit_slot_reg;
        end else if (emp_fnd_reg) begin
            slot_sel = emp_slot_reg;
        end else begin
            slot_sel = best_slot_reg;
        end
    end

    always_comb begin
        if (clear_reg) begin
            fault_next = '0;
        end else if (miss && fault_reg != CNT_MAX) begin
            fault_next = fault_reg + CNT_W'(1);
        end else begin
            fault_next = fault_reg;
        end
    end

    always_comb begin
        if (clear_reg) begin
            out_data_next = '0;
        end else begin
            out_data_next = {
                (OUT_TDATA_W - 53)'(0),
                fault_next,
                ev_valid ? PAGE_W'(best_page_reg) : PAGE_W'(0),
                ev_valid,
                SLOT_W'(slot_sel),
                hit_fnd_reg
            };
        end
    end

    assign pg_we = cmd.commit && !clear_reg && miss;
    assign st_we = cmd.commit && !clear_reg;

    lpr_ram #(.WIDTH(PW), .DEPTH(FRAMES)) u_page_ram (
        .aclk  (aclk),
        .we    (pg_we),
        .waddr (slot_sel),
        .wdata (page_reg),
        .raddr (idx_reg),
        .rdata (pg_rd)
    );

    lpr_ram #(.WIDTH(CNT_W), .DEPTH(FRAMES)) u_stamp_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (slot_sel),
        .wdata (stamp_reg),
        .raddr (idx_reg),
        .rdata (st_rd)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            af_reg      <= AF_RESET;
            valid_reg   <= '0;
            ref_cnt_reg <= '0;
            fault_reg   <= '0;
            out_vld_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                af_reg <= cfg_wr_data;
            end
            cmp_vld_reg <= cmd.step;
            if (cmd.load && !sts.in_clear && ref_cnt_reg != CNT_MAX) begin
                ref_cnt_reg <= ref_cnt_reg + CNT_W'(1);
            end
            if (cmd.commit) begin
                fault_reg <= fault_next;
                if (clear_reg) begin
                    valid_reg   <= '0;
                    ref_cnt_reg <= '0;
                end else begin
                    valid_reg[slot_sel] <= 1'b1;
                end
            end
            if (cmd.commit) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Scan payload; flags are reset by each load
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            clear_reg   <= sts.in_clear;
            page_reg    <= s_tdata[PW-1:0];
            stamp_reg   <= ref_cnt_reg;
            idx_reg     <= '0;
            hit_fnd_reg <= 1'b0;
            emp_fnd_reg <= 1'b0;
        end else if (cmd.step) begin
            idx_reg <= idx_reg + IW'(1);
        end
        cmp_idx_reg <= idx_reg;
        if (cmp_vld_reg) begin
            if (cmp_v && pg_rd == page_reg && !hit_fnd_reg) begin
                hit_fnd_reg  <= 1'b1;
                hit_slot_reg <= cmp_idx_reg;
            end
            if (!cmp_v && !emp_fnd_reg) begin
                emp_fnd_reg  <= 1'b1;
                emp_slot_reg <= cmp_idx_reg;
            end
            if (cmp_idx_reg == '0 || st_rd < best_stamp_reg) begin
                best_stamp_reg <= st_rd;
                best_slot_reg  <= cmp_idx_reg;
                best_page_reg  <= pg_rd;
            end
        end
        if (cmd.commit) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- design/lru_page_replacement.sv -----
// Top level of the LRU page replacement block.
// Depends on lpr_pkg, lpr_ctrl and lpr_dpath (which holds two lpr_ram tables).
`default_nettype none

// LRU page replacement unit. Each input item is either a page reference
// (tuser = 0) or a clear command (tuser = 1). A reference looks up the page in
// a fully associative set of FRAMES frames, limited to the first active_frames
// of them (0 acts as 1, values above FRAMES act as FRAMES). On a hit the frame's
// last-use stamp is refreshed; on a miss the lowest empty frame is filled, or
// the least recently used frame is replaced (lowest index on a tie) and its
// page reported. Every miss bumps a saturating fault count. A clear empties all
// frames and zeroes the counters and returns an all-zero result. One result
// item per input item. A reference is accepted, its active frames are scanned,
// the last compare is drained and the result committed once the output
// register is free; only then is the next item accepted. A clear skips the
// scan and drain. The scan reads one frame per cycle from the page and stamp
// tables through their registered read port.
// The result sits in an output register, so the next item is accepted while
// it waits. Frame valid bits are flops cleared by reset: no clearing pass.
// Write active_frames only while the block is idle.
module lru_page_replacement #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input item
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lpr_pkg::IN_TDATA_W-1:0]   s_tdata,   // [15:0] page
    input  wire logic [lpr_pkg::IN_TUSER_W-1:0]   s_tuser,   // [0] cmd
    // result item
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [0] hit, [3:1] slot, [4] evicted_valid, [20:5] evicted_page,
    // [52:21] fault_count, [55:53] zero
    output logic      [lpr_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // active_frames register
    input  wire logic                             cfg_wr_en,
    input  wire logic [lpr_pkg::AF_W-1:0]         cfg_wr_data
);
    import lpr_pkg::*;

    ctrl_cmd_t ctl_cmd;
    ctrl_sts_t ctl_sts;

    // Sequencer: accept, scan, drain last compare, commit
    lpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (ctl_sts),
        .cmd      (ctl_cmd)
    );

    // Tables, compare logic, counters, output register
    lpr_dpath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (ctl_cmd),
        .sts         (ctl_sts),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

    // A result is never committed over one still waiting
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_cmd.commit |-> (!m_tvalid || m_tready))
        else $error("result committed over a pending item");

    // A commit always shows up on the result channel
    a_commit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_cmd.commit |=> m_tvalid)
        else $error("commit did not raise m_tvalid");

    // Clear accepted with an empty output gives an all-zero result once committed
    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == CMD_CLEAR && !m_tvalid)
        |-> ##2 (m_tvalid && m_tdata == '0))
        else $error("clear result missing or nonzero");

    // Controller issues at most one command per cycle
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctl_cmd.load, ctl_cmd.step, ctl_cmd.commit}))
        else $error("overlapping controller commands");

endmodule

`default_nettype wire

// ----- tb/sv/lpr_tracker_pkg.sv -----
// Scoreboard for the LRU page replacement testbench: frame-table predictor
// plus an in-order queue of expected result items. Depends on lpr_pkg.
package lpr_tracker_pkg;

    import lpr_pkg::*;

    localparam int NUM_FRAMES = 8;

    typedef struct {
        bit               hit;
        bit [SLOT_W-1:0]  slot;
        bit               ev_valid;
        bit [PAGE_W-1:0]  ev_page;
        bit [CNT_W-1:0]   faults;
    } page_result_t;

    class lru_frame_tracker;
        bit [AF_W-1:0]    af_reg;
        bit               frm_valid [NUM_FRAMES];
        bit [PAGE_W-1:0]  frm_page  [NUM_FRAMES];
        bit [CNT_W-1:0]   frm_stamp [NUM_FRAMES];
        bit [CNT_W-1:0]   refs;
        bit [CNT_W-1:0]   faults;
        page_result_t     expected_q[$];
        int unsigned      errors;

        function new();
            af_reg = AF_RESET;
            errors = 0;
            clear_frames();
        endfunction

        function void clear_frames();
            for (int i = 0; i < NUM_FRAMES; i++) begin
                frm_valid[i] = 1'b0;
                frm_page[i]  = '0;
                frm_stamp[i] = '0;
            end
            refs   = '0;
            faults = '0;
        endfunction

        function void set_active_frames(bit [AF_W-1:0] v);
            af_reg = v;
        endfunction

        // 0 acts as 1, anything above the built count acts as the full set
        function int unsigned frames_in_use();
            if (af_reg == 0)
                return 1;
            if (af_reg > NUM_FRAMES)
                return NUM_FRAMES;
            return af_reg;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Called when an input item is accepted
        function void note_item(bit cmd, bit [PAGE_W-1:0] page);
            page_result_t      r;
            int unsigned       n;
            int unsigned       slot;
            bit                found;
            bit [CNT_W-1:0]    stamp;
            bit [CNT_W-1:0]    oldest;
            r = '{default: '0};
            if (cmd == CMD_CLEAR) begin
                clear_frames();
                expected_q.push_back(r);
                return;
            end
            n = frames_in_use();
            stamp = refs;
            if (refs != CNT_MAX)
                refs++;
            found = 1'b0;
            slot = 0;
            for (int i = 0; i < n; i++) begin
                if (!found && frm_valid[i] && frm_page[i] == page) begin
                    slot = i;
                    found = 1'b1;
                    r.hit = 1'b1;
                end
            end
            if (!found) begin
                for (int i = 0; i < n; i++) begin
                    if (!found && !frm_valid[i]) begin
                        slot = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    // strict compare keeps the lowest index on a tie
                    oldest = frm_stamp[0];
                    slot = 0;
                    for (int i = 1; i < n; i++) begin
                        if (frm_stamp[i] < oldest) begin
                            oldest = frm_stamp[i];
                            slot = i;
                        end
                    end
                    r.ev_valid = 1'b1;
                    r.ev_page  = frm_page[slot];
                end
                frm_valid[slot] = 1'b1;
                frm_page[slot]  = page;
                if (faults != CNT_MAX)
                    faults++;
            end
            frm_stamp[slot] = stamp;
            r.slot   = slot[SLOT_W-1:0];
            r.faults = faults;
            expected_q.push_back(r);
        endfunction

        function void cmp_field(string name, logic [CNT_W-1:0] exp_v, logic [CNT_W-1:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        // Called when a result item is accepted
        function void check_result(logic [OUT_TDATA_W-1:0] data);
            page_result_t e;
            if (expected_q.size() == 0) begin
                $error("result item with no expectation: 0x%0h", data);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            cmp_field("hit",           CNT_W'(e.hit),      CNT_W'(data[0]));
            cmp_field("slot",          CNT_W'(e.slot),     CNT_W'(data[3:1]));
            cmp_field("evicted_valid", CNT_W'(e.ev_valid), CNT_W'(data[4]));
            cmp_field("evicted_page",  CNT_W'(e.ev_page),  CNT_W'(data[20:5]));
            cmp_field("fault_count",   e.faults,           data[52:21]);
        endfunction
    endclass

endpackage

// ----- tb/sv/lru_page_replacement_tb.sv -----
// Top-level testbench for lru_page_replacement: drives page references and
// clears, checks every result item. Depends on lpr_pkg and lpr_tracker_pkg.
module lru_page_replacement_tb;

    import lpr_pkg::*;
    import lpr_tracker_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int ITEMS_PER_PH = 140;
    localparam int TAIL_CYCLES  = 20;

    logic                    aclk;
    logic                    aresetn     = 1'b0;
    logic                    s_tvalid    = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata     = '0;   // [15:0] page
    logic [IN_TUSER_W-1:0]   s_tuser     = '0;   // [0] cmd
    logic                    m_tvalid;
    logic                    m_tready    = 1'b0;
    // [0] hit, [3:1] slot, [4] evicted_valid, [20:5] evicted_page,
    // [52:21] fault_count, [55:53] zero
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_wr_en   = 1'b0;
    logic [AF_W-1:0]         cfg_wr_data = '0;

    lru_frame_tracker tracker;

    // Idle percentages per side; the hold request asks the receiver for
    // a long back-pressure stretch.
    int unsigned tx_idle_pct = 34;
    int unsigned rx_idle_pct = 34;
    bit          hold_req    = 1'b0;
    int unsigned cycle_cnt   = 0;

    lru_page_replacement uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Sender. Entered and left at a falling edge; tvalid stays high from
    // one item to the next unless an idle cycle is drawn.
    task automatic send_item(input logic cmd, input logic [PAGE_W-1:0] page);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= page;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        tracker.note_item(cmd, page);
        @(negedge aclk);
    endtask

    task automatic send_ref(input logic [PAGE_W-1:0] page);
        send_item(CMD_REF, page);
    endtask

    // Stop offering and wait for every expected result. Every item makes a
    // result, so once the queue is empty the block is idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (tracker.pending() != 0);
    endtask

    // Register write, only while idle; predictor copy follows at the edge
    task automatic write_active_frames(input logic [AF_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        tracker.set_active_frames(v);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random phase: mostly references from a small page pool so hits and
    // LRU evictions happen often, some fully random pages, rare clears.
    task automatic run_random_phase(input int unsigned count);
        logic [PAGE_W-1:0] pool [16];
        int unsigned       pool_size;
        int unsigned       r;
        pool_size = $urandom_range(12, 2);
        for (int i = 0; i < 16; i++)
            pool[i] = PAGE_W'($urandom_range(65535, 0));
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 3)
                send_item(CMD_CLEAR, PAGE_W'($urandom));
            else if (r < 80)
                send_ref(pool[$urandom_range(pool_size - 1, 0)]);
            else
                send_ref(PAGE_W'($urandom));
        end
    endtask

    // Receiver: draws tready at each falling edge, checks on handshake.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                tracker.check_result(m_tdata);
        end
    end

    // Watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int unsigned af_plan [12];
        af_plan = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd12, 4'd7, 4'd4, 4'd6, 4'd8};
        tracker = new();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed part, reset value of 8 frames ---
        send_ref(16'h0000);            // fill frame 0, lowest page
        send_ref(16'hFFFF);            // fill frame 1, highest page
        send_ref(16'h0000);            // hit, refreshes frame 0
        send_ref(16'h0001);
        send_ref(16'h0002);
        send_ref(16'h0004);
        send_ref(16'h8000);
        send_ref(16'h5555);
        send_ref(16'hAAAA);            // all eight frames now full
        send_ref(16'h1234);            // evicts LRU: 16'hFFFF in frame 1
        send_ref(16'hFFFF);            // miss again, evicts frame 0
        drain();

        // shrunk set: frames 2..7 are neither searched nor filled
        write_active_frames(4'd2);
        send_ref(16'h5555);            // lives in frame 6, misses here
        drain();
        write_active_frames(4'd8);
        send_ref(16'hAAAA);            // frame 7 contents reappear: hit
        send_item(CMD_CLEAR, 16'hBEEF);
        send_ref(16'hAAAA);            // miss after clear, fault count 1
        drain();

        // zero acts as one frame
        write_active_frames(4'd0);
        send_ref(16'h00F0);
        send_ref(16'h0F00);            // replaces the single frame
        send_ref(16'h0F00);            // hit
        drain();

        // oversized value acts as the full set
        write_active_frames(4'd15);
        send_ref(16'h7FFF);
        send_ref(16'h0F00);
        send_item(CMD_CLEAR, 16'h0000);
        drain();

        // --- random phases across register settings ---
        for (int p = 0; p < 12; p++) begin
            write_active_frames(af_plan[p][AF_W-1:0]);
            tx_idle_pct = 34;
            rx_idle_pct = 34;
            if (p == 5) begin
                // long stretch without idling on either side
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p == 2 || p == 9)
                hold_req = 1'b1;       // receiver stalls, input backs up
            run_random_phase(ITEMS_PER_PH);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
